// ===== design/line_sensor_calibrate_position_unit_macros.svh =====
`ifndef LINE_SENSOR_CALIBRATE_POSITION_UNIT_MACROS_SVH
`define LINE_SENSOR_CALIBRATE_POSITION_UNIT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define LSCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lscp same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define LSCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lscp next-cycle check failed");

`endif

// ===== design/lscp_pkg.sv =====
package lscp_pkg;

    // Item geometry
    localparam int SENSORS    = 5;
    localparam int ADC_W      = 12;
    localparam int SEL_W      = $clog2(SENSORS);
    localparam int CFG_IDX_W  = 8;

    // Normalized value: 4096 is full scale
    localparam int NORM_SHIFT = 12;
    localparam int NORM_W     = NORM_SHIFT + 1;

    // Weights and position, signed Q1.14
    localparam int W_W        = 16;
    localparam int PROD_W     = NORM_W + 1 + W_W;
    localparam int ACC_W      = 32;

    // Shared divider: 32-bit dividend, 16 quotient bits, 8 bits per cycle
    localparam int NUM_W      = ACC_W;
    localparam int QUO_W      = 16;
    localparam int DEN_W      = $clog2(SENSORS * (2 ** (W_W - 1)) + 1);
    localparam int DIV_STEPS  = 2;
    localparam int DIV_BITS   = QUO_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef logic [ADC_W-1:0]         t_sample;
    typedef logic [NORM_W-1:0]        t_norm;
    typedef logic signed [W_W-1:0]    t_weight;

    localparam t_norm   NORM_ONE    = t_norm'(2 ** NORM_SHIFT);
    localparam t_sample CAL_MAX_RST = t_sample'(1500);
    localparam t_sample CAL_MIN_RST = t_sample'(1000);
    localparam t_weight POS_MAX     = 16'sh7FFF;
    localparam t_weight NEG_MIN     = 16'sh8000;
    localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(2 ** (W_W - 1));

    localparam t_weight WEIGHT_RST [SENSORS] = '{
        -16'sd8192, -16'sd16384, 16'sd0, 16'sd16384, 16'sd8192
    };

    // Item commands
    localparam logic [1:0] CMD_RESET_CAL  = 2'd0;
    localparam logic [1:0] CMD_UPDATE_CAL = 2'd1;
    localparam logic [1:0] CMD_MEASURE    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAL,
        S_LOAD,
        S_RUN,
        S_ACC,
        S_SUM,
        S_PREP,
        S_PLOAD,
        S_PRUN,
        S_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic             accept;
        logic             cal;
        logic             ld_norm;
        logic             acc;
        logic             prep_pos;
        logic             ld_pos;
        logic             step;
        logic             fin;
        logic [SEL_W-1:0] sel;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_ctrl_sts;

endpackage

// ===== design/lscp_ifs.sv =====
interface lscp_in_if import lscp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    t_sample    sample_left;
    t_sample    sample_center_left;
    t_sample    sample_center;
    t_sample    sample_center_right;
    t_sample    sample_right;

    modport source (
        output valid, cmd, sample_left, sample_center_left, sample_center,
               sample_center_right, sample_right,
        input  ready
    );
    modport sink (
        input  valid, cmd, sample_left, sample_center_left, sample_center,
               sample_center_right, sample_right,
        output ready
    );
endinterface

interface lscp_out_if import lscp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_norm   norm_left;
    t_norm   norm_center_left;
    t_norm   norm_center;
    t_norm   norm_center_right;
    t_norm   norm_right;
    t_weight line_position;
    logic    divisor_zero;

    modport source (
        output valid, norm_left, norm_center_left, norm_center, norm_center_right,
               norm_right, line_position, divisor_zero,
        input  ready
    );
    modport sink (
        input  valid, norm_left, norm_center_left, norm_center, norm_center_right,
               norm_right, line_position, divisor_zero,
        output ready
    );
endinterface

interface lscp_cfg_if import lscp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [W_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/lscp_div.sv =====
module lscp_div import lscp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_last
);

    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     n_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [QUO_W-1:0]     n_quo;
    logic [DEN_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;

    // Restoring division, DIV_BITS quotient bits per step
    always_comb begin
        logic [DEN_W:0]   v_rem;
        logic [QUO_W-1:0] v_quo;
        v_rem = {1'b0, r_rem};
        v_quo = r_quo;
        for (int i = 0; i < DIV_BITS; i++) begin
            v_rem = {v_rem[DEN_W-1:0], v_quo[QUO_W-1]};
            v_quo = {v_quo[QUO_W-2:0], 1'b0};
            if (v_rem >= {1'b0, r_den}) begin
                v_rem    = v_rem - {1'b0, r_den};
                v_quo[0] = 1'b1;
            end
        end
        n_rem = v_rem[DEN_W-1:0];
        n_quo = v_quo;
    end

    // Load dividend high part as the remainder, low part shifts out MSB first
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= {{(DEN_W - (NUM_W - QUO_W)){1'b0}}, i_num[NUM_W-1:QUO_W]};
            r_quo <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Count steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_quo  = r_quo;
    assign o_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

// ===== design/lscp_datapath.sv =====
`include "line_sensor_calibrate_position_unit_macros.svh"

module lscp_datapath import lscp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_ctrl_sts            o_sts,
    input  logic [1:0]           i_in_cmd,
    input  t_sample              i_samples [SENSORS],
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [W_W-1:0]       i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_norm                o_norm [SENSORS],
    output t_weight              o_line_position,
    output logic                 o_divisor_zero
);

    logic [1:0]        r_in_cmd;
    t_sample           r_samp [SENSORS];
    t_weight           r_weight [SENSORS];
    t_sample           r_cal_max [SENSORS];
    t_sample           r_cal_min [SENSORS];

    t_sample           w_s;
    t_sample           w_lo;
    t_sample           w_hi;
    t_weight           w_w;
    t_sample           w_diff;
    t_sample           w_span;
    logic [NUM_W-1:0]  w_norm_num;
    logic [DEN_W-1:0]  w_norm_den;
    logic              r_le_lo;
    logic              r_full;
    t_norm             w_norm;
    logic signed [PROD_W-1:0] w_prod;
    logic [W_W:0]      w_wmag;

    t_norm             r_norm [SENSORS];
    logic signed [PROD_W-1:0] r_prod;
    logic              r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DEN_W-1:0]  r_pos;
    logic [DEN_W-1:0]  r_neg;

    logic [ACC_W-1:0]  w_abs;
    logic [NUM_W-1:0]  r_pnum;
    logic [DEN_W-1:0]  r_pden;
    logic              r_neg_side;
    logic              r_dz;
    logic              r_ovf;

    logic              w_div_load;
    logic [NUM_W-1:0]  w_div_num;
    logic [DEN_W-1:0]  w_div_den;
    logic [QUO_W-1:0]  w_quo;
    logic              w_div_last;
    t_weight           w_position;

    logic              r_out_valid;
    t_norm             r_out_norm [SENSORS];
    t_weight           r_out_pos;
    logic              r_out_dz;

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_cmd <= i_in_cmd;
            r_samp   <= i_samples;
        end
    end

    // Weight registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RST;
        end else if (i_cfg_wr && (i_cfg_index < CFG_IDX_W'(SENSORS))) begin
            r_weight[i_cfg_index[SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // Calibration limits: reset or widen, all sensors at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SENSORS; i++) begin
                r_cal_max[i] <= CAL_MAX_RST;
                r_cal_min[i] <= CAL_MIN_RST;
            end
        end else if (i_cmd.cal) begin
            for (int i = 0; i < SENSORS; i++) begin
                case (r_in_cmd)
                    CMD_RESET_CAL: begin
                        r_cal_max[i] <= CAL_MAX_RST;
                        r_cal_min[i] <= CAL_MIN_RST;
                    end
                    CMD_UPDATE_CAL: begin
                        if (r_samp[i] > r_cal_max[i]) r_cal_max[i] <= r_samp[i];
                        if (r_samp[i] < r_cal_min[i]) r_cal_min[i] <= r_samp[i];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Per-sensor operands
    assign w_s        = r_samp[i_cmd.sel];
    assign w_lo       = r_cal_min[i_cmd.sel];
    assign w_hi       = r_cal_max[i_cmd.sel];
    assign w_w        = r_weight[i_cmd.sel];
    assign w_diff     = w_s - w_lo;
    assign w_span     = w_hi - w_lo;
    assign w_norm_num = {{(NUM_W - ADC_W - NORM_SHIFT){1'b0}}, w_diff, {NORM_SHIFT{1'b0}}};
    assign w_norm_den = {{(DEN_W - ADC_W){1'b0}}, w_span};

    // Classify the sample against its limits; use the quotient only inside the range
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_norm) begin
            r_le_lo <= (w_s <= w_lo);
            r_full  <= (w_hi <= w_lo) || (w_s >= w_hi);
        end
    end

    assign w_norm = r_le_lo ? '0 : (r_full ? NORM_ONE : w_quo[NORM_W-1:0]);
    assign w_prod = $signed({1'b0, w_norm}) * w_w;
    assign w_wmag = (W_W + 1)'(0) - {w_w[W_W-1], w_w};

    // Store the norm, form its product, split weights by sign
    always_ff @(posedge i_clk) begin
        if (i_cmd.cal) begin
            r_pos <= '0;
            r_neg <= '0;
        end else if (i_cmd.acc) begin
            r_norm[i_cmd.sel] <= w_norm;
            r_prod            <= w_prod;
            if (w_w > 0) begin
                r_pos <= r_pos + {{(DEN_W - W_W){1'b0}}, w_w};
            end else begin
                r_neg <= r_neg + {{(DEN_W - W_W - 1){1'b0}}, w_wmag};
            end
        end
    end

    // Add each product in the cycle after it is formed
    always_ff @(posedge i_clk) begin
        if (i_cmd.cal) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.acc;
        end
    end

    // Position operands: magnitude of 4*sum over the chosen weight sum
    assign w_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep_pos) begin
            r_pnum     <= {w_abs[ACC_W-3:0], 2'b00};
            r_neg_side <= !(r_acc > 0);
            r_pden     <= (r_acc > 0) ? r_pos : r_neg;
            r_dz       <= (r_acc > 0) ? (r_pos == '0) : (r_neg == '0);
        end
        if (i_cmd.ld_pos) begin
            r_ovf <= ({{(DEN_W - (NUM_W - QUO_W)){1'b0}}, r_pnum[NUM_W-1:QUO_W]} >= r_pden);
        end
    end

    // Shared divider
    assign w_div_load = i_cmd.ld_norm | i_cmd.ld_pos;
    assign w_div_num  = i_cmd.ld_pos ? r_pnum : w_norm_num;
    assign w_div_den  = i_cmd.ld_pos ? r_pden : w_norm_den;

    lscp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_div_load),
        .i_step (i_cmd.step),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_quo  (w_quo),
        .o_last (w_div_last)
    );

    // Force zero on a zero divisor, else apply sign and saturate the quotient
    always_comb begin
        if (r_dz) begin
            w_position = '0;
        end else if (!r_neg_side) begin
            w_position = (r_ovf || w_quo[QUO_W-1]) ? POS_MAX : $signed(w_quo);
        end else begin
            w_position = (r_ovf || (w_quo > NEG_LIMIT)) ? NEG_MIN : $signed(QUO_W'(-w_quo));
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_norm <= r_norm;
            r_out_pos  <= w_position;
            r_out_dz   <= r_dz;
        end
    end

    assign o_sts.div_last  = w_div_last;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_norm          = r_out_norm;
    assign o_line_position = r_out_pos;
    assign o_divisor_zero  = r_out_dz;

    `LSCP_ASSERT_NOW(a_norm_range, i_clk, i_rst_n, i_cmd.acc, w_norm <= NORM_ONE)
    `LSCP_ASSERT_NEXT(a_prod_once, i_clk, i_rst_n, r_prod_vld, !r_prod_vld)
    `LSCP_ASSERT_NOW(a_dz_zero, i_clk, i_rst_n, r_out_valid && r_out_dz, r_out_pos == '0)

endmodule

// ===== design/lscp_ctrl.sv =====
`include "line_sensor_calibrate_position_unit_macros.svh"

module lscp_ctrl import lscp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output t_ctrl_cmd o_cmd,
    input  t_ctrl_sts i_sts
);

    t_state           r_state;
    t_state           n_state;
    logic [SEL_W-1:0] r_sel;
    logic [SEL_W-1:0] n_sel;

    // State and sensor counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    // Sequence: calibrate, five normalizations, then the position division
    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CAL;
                end
            end
            S_CAL: begin
                o_cmd.cal = 1'b1;
                n_sel     = '0;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.ld_norm = 1'b1;
                n_state       = S_RUN;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_sel == SEL_W'(SENSORS - 1)) begin
                    n_sel   = '0;
                    n_state = S_SUM;
                end else begin
                    n_sel   = r_sel + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_SUM: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep_pos = 1'b1;
                n_state        = S_PLOAD;
            end
            S_PLOAD: begin
                o_cmd.ld_pos = 1'b1;
                n_state      = S_PRUN;
            end
            S_PRUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `LSCP_ASSERT_NEXT(a_accept_cal, i_clk, i_rst_n, o_cmd.accept, r_state == S_CAL)
    `LSCP_ASSERT_NOW(a_sel_range, i_clk, i_rst_n, 1'b1, r_sel <= SEL_W'(SENSORS - 1))
    `LSCP_ASSERT_NEXT(a_last_sensor, i_clk, i_rst_n, (r_state == S_ACC) && (r_sel == SEL_W'(SENSORS - 1)), r_state == S_SUM)

endmodule

// ===== design/line_sensor_calibrate_position_unit.sv =====
// The shared 8-bit-per-cycle divider runs six divisions per item: one
// normalization per sensor, then the position. A new item is accepted only
// after the last one has been written to the output register.
// A finished result waits in the output register while the next item runs.
// Reset (synchronous, active low) restores the weights to their defaults and
// the calibration limits to 1500 / 1000, and empties the output register.
module line_sensor_calibrate_position_unit import lscp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lscp_in_if.sink    i_in,
    lscp_out_if.source o_out,
    lscp_cfg_if.sink   i_cfg
);

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;
    logic      w_in_ready;
    t_sample   w_samples [SENSORS];
    t_norm     w_norm [SENSORS];

    assign w_samples[0] = i_in.sample_left;
    assign w_samples[1] = i_in.sample_center_left;
    assign w_samples[2] = i_in.sample_center;
    assign w_samples[3] = i_in.sample_center_right;
    assign w_samples[4] = i_in.sample_right;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    lscp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(w_in_ready),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    lscp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_in_cmd       (i_in.cmd),
        .i_samples      (w_samples),
        .i_cfg_wr       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_norm         (w_norm),
        .o_line_position(o_out.line_position),
        .o_divisor_zero (o_out.divisor_zero)
    );

    assign o_out.norm_left         = w_norm[0];
    assign o_out.norm_center_left  = w_norm[1];
    assign o_out.norm_center       = w_norm[2];
    assign o_out.norm_center_right = w_norm[3];
    assign o_out.norm_right        = w_norm[4];

endmodule
